>>> hdl/float32_goldschmidt_divider_core_assert.svh
// Assertion macros for the float32 Goldschmidt divider
`ifndef FLOAT32_GOLDSCHMIDT_DIVIDER_CORE_ASSERT_SVH
`define FLOAT32_GOLDSCHMIDT_DIVIDER_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define FGD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication outside reset
`define FGD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hdl/fgd_pkg.sv
// ----------------------------------------------------------------------------
// fgd_pkg
// Shared constants and stage types for the Goldschmidt divider.
// ----------------------------------------------------------------------------
package fgd_pkg;
  localparam int unsigned RefineSteps = 6;
  localparam logic [31:0] SignMask = 32'h8000_0000;
  localparam logic [31:0] ExpMask  = 32'h7F80_0000;
  localparam logic [31:0] FracMask = 32'h007F_FFFF;
  localparam logic [31:0] ExpOne   = 32'h0080_0000;
  localparam logic [31:0] BiasHi   = 32'h3F80_0000;
  localparam logic [31:0] BiasLo   = 32'h3F00_0000;
  localparam logic [31:0] SeedLow  = 32'h3000_0000;
  localparam logic [31:0] SeedHigh = 32'h2800_0000;

  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_ZERO   = 2'd1,
    KIND_INF    = 2'd2
  } kind_e;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] d;
    logic [31:0] e1;
    logic [31:0] e2;
    logic [31:0] sign;
    kind_e       kind;
  } stage_t;
endpackage

>>> hdl/fgd_step.sv
// ----------------------------------------------------------------------------
// fgd_step
// One registered Goldschmidt refinement step: products X*D and Y*D.
// ----------------------------------------------------------------------------
module fgd_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  fgd_pkg::stage_t st_i,
  output logic            valid_o,
  output fgd_pkg::stage_t st_o,
  output logic [63:0]     px_o
);
  logic [63:0] px_d, py_d, px_q;
  logic        valid_q;
  fgd_pkg::stage_t st_d, st_q;

  always_comb begin
    px_d   = {32'd0, st_i.x} * {32'd0, st_i.d};
    py_d   = {32'd0, st_i.y} * {32'd0, st_i.d};
    st_d   = st_i;
    st_d.x = px_d[62:31];
    st_d.y = py_d[62:31];
    st_d.d = 32'd0 - py_d[62:31];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
      px_q <= px_d;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;
  assign px_o    = px_q;
endmodule

>>> hdl/float32_goldschmidt_divider_core.sv
// ----------------------------------------------------------------------------
// float32_goldschmidt_divider_core
// Float32 divider, pipelined Goldschmidt refinement, truncated result.
// ----------------------------------------------------------------------------
// Pipeline: setup stage, one stage per refinement step, pack stage.
// Throughput: one transaction per cycle; the pipeline stalls as a whole
//   when the output is held and its last stage is full.
// Reset: rst_ni clears all valid bits asynchronously; data is not reset.
`include "float32_goldschmidt_divider_core_assert.svh"
module float32_goldschmidt_divider_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] dividend, [63:32] divisor
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // [31:0] quotient
);
  localparam int unsigned N = fgd_pkg::RefineSteps;

  logic en;
  logic [N:0]            vld;
  fgd_pkg::stage_t       st [N+1];
  logic [63:0]           px [N+1];
  fgd_pkg::stage_t       s0_d;
  logic [31:0]           a, b, ediff;
  logic                  out_v_q;
  logic [31:0]           out_q, out_d;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;
  assign a = s_axis_tdata[31:0];
  assign b = s_axis_tdata[63:32];
  assign ediff = (a & fgd_pkg::ExpMask) - (b & fgd_pkg::ExpMask);

  always_comb begin
    s0_d.sign = (a ^ b) & fgd_pkg::SignMask;
    s0_d.x    = fgd_pkg::SignMask | {1'b0, a[22:0], 8'd0};
    s0_d.y    = fgd_pkg::SignMask | {1'b0, b[22:0], 8'd0};
    s0_d.d    = b[22] ? fgd_pkg::SeedHigh : fgd_pkg::SeedLow;
    s0_d.e1   = ediff + fgd_pkg::BiasHi;
    s0_d.e2   = ediff + fgd_pkg::BiasLo;
    if (s0_d.x < s0_d.y) begin
      s0_d.y  = s0_d.y >> 1;
      s0_d.d  = s0_d.d << 1;
      s0_d.e1 = s0_d.e1 - fgd_pkg::ExpOne;
      s0_d.e2 = s0_d.e2 - fgd_pkg::ExpOne;
    end
    if (a[30:0] == 31'd0) begin
      s0_d.kind = fgd_pkg::KIND_ZERO;
    end else if (b[30:0] == 31'd0) begin
      s0_d.kind = fgd_pkg::KIND_INF;
    end else begin
      s0_d.kind = fgd_pkg::KIND_NORMAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st[0] <= s0_d;
    end
  end
  assign px[0] = 64'd0;

  for (genvar g = 0; g < N; g++) begin : g_step
    fgd_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[g]),
      .st_i    (st[g]),
      .valid_o (vld[g+1]),
      .st_o    (st[g+1]),
      .px_o    (px[g+1])
    );
  end

  always_comb begin
    unique case (st[N].kind)
      fgd_pkg::KIND_ZERO: out_d = st[N].sign;
      fgd_pkg::KIND_INF:  out_d = st[N].sign | fgd_pkg::ExpMask;
      default: begin
        if (px[N][62]) begin
          out_d = st[N].sign | st[N].e1 | {9'd0, px[N][61:39]};
        end else begin
          out_d = st[N].sign | st[N].e2 | {9'd0, px[N][60:38]};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= vld[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  `FGD_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `FGD_ASSERT_IMP(a_ready, !s_axis_tready, m_axis_tvalid)
  `FGD_ASSERT_NXT(a_adv, en && vld[N], m_axis_tvalid)
endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams float32 operand pairs into the Goldschmidt divider with random
// idle bursts and a long output hold-off, predicts each truncated quotient
// and checks the results in order.
// ----------------------------------------------------------------------------
class quotient_scoreboard;
  logic [31:0] pending_q[$];
  int unsigned errors;

  function void note_operands(logic [31:0] a, logic [31:0] b);
    pending_q.push_back(predict_quotient(a, b));
  endfunction

  function void check_quotient(logic [31:0] got);
    logic [31:0] want;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected quotient, expected none, actual %h", $time, got);
      errors++;
    end else begin
      want = pending_q.pop_front();
      if (want !== got) begin
        $display("%0t: quotient expected %h, actual %h", $time, want, got);
        errors++;
      end
    end
  endfunction

  function logic [31:0] predict_quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] sgn, x, y, d, ediff, e1, e2;
    logic [63:0] px, py;
    sgn = (a ^ b) & fgd_pkg::SignMask;
    x = {1'b1, a[22:0], 8'd0};
    y = {1'b1, b[22:0], 8'd0};
    d = b[22] ? fgd_pkg::SeedHigh : fgd_pkg::SeedLow;
    ediff = (a & fgd_pkg::ExpMask) - (b & fgd_pkg::ExpMask);
    e1 = ediff + fgd_pkg::BiasHi;
    e2 = ediff + fgd_pkg::BiasLo;
    if (x < y) begin
      y = y >> 1;
      d = d << 1;
      e1 = e1 - fgd_pkg::ExpOne;
      e2 = e2 - fgd_pkg::ExpOne;
    end
    px = 64'(x) * 64'(d);
    py = 64'(y) * 64'(d);
    for (int s = 1; s < fgd_pkg::RefineSteps; s++) begin
      x = px[62:31];
      y = py[62:31];
      d = -y;
      px = 64'(x) * 64'(d);
      py = 64'(y) * 64'(d);
    end
    if (a[30:0] == 0) return sgn;
    if (b[30:0] == 0) return sgn | fgd_pkg::ExpMask;
    if (px[62]) return sgn | e1 | (px[61:39] & fgd_pkg::FracMask);
    return sgn | e2 | ({9'd0, px[60:38]});
  endfunction
endclass

module tb_top;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  quotient_scoreboard sb = new();
  bit quiet_phase = 1'b0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  always #2 clk_i = ~clk_i;

  float32_goldschmidt_divider_core u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  function automatic logic [31:0] rand_float();
    logic [31:0] f;
    f = $urandom();
    case ($urandom_range(0, 7))
      0: f[30:23] = $urandom_range(0, 3) == 0 ? 8'h00 : 8'hFF;
      1: f[30:0] = '0;
      2: f[22:0] = $urandom_range(0, 1) ? '0 : 23'h7FFFFF;
      default: f[30:23] = $urandom_range(100, 154);
    endcase
    return f;
  endfunction

  task automatic send_pair(logic [31:0] a, logic [31:0] b);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_operands(a, b);
  endtask

  initial begin
    logic [31:0] edge_ops[8];
    edge_ops = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBFC0_0000,
                 32'h7F7F_FFFF, 32'h0080_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 6; j++)
        send_pair(edge_ops[(i * 2 + j) % 8], edge_ops[(j * 3 + i) % 8]);
    for (int n = 0; n < 1950; n++) begin
      if (n == 300) hold_off = 1'b1;
      if (n == 1700) quiet_phase = 1'b1;
      send_pair(rand_float(), rand_float());
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int stall;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        hold_off = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (60) @(posedge clk_i);
      end
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 6);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_quotient(m_axis_tdata);

  initial begin
    wait (stim_done);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("float32_goldschmidt_divider_core: match");
    else $display("float32_goldschmidt_divider_core: mismatch");
    $finish;
  end

  initial begin
    #1000000;
    $display("float32_goldschmidt_divider_core: mismatch");
    $finish;
  end
endmodule
